### src/stereo_feedback_delay_macros.svh
// ----------------------------------------------------------------------------
// Stereo feedback delay assertion macros
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_MACROS_SVH
`define STEREO_FEEDBACK_DELAY_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define SFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define SFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay package
// Formats, register codes, controller types and the output saturator.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

	localparam int RING_DEPTH  = 131072;
	localparam int RING_AW     = $clog2(RING_DEPTH);
	localparam int SAMPLE_BITS = 24;
	localparam int SAT_BITS    = 48;

	localparam int DELAY_BITS = 17;
	localparam int FRAC_BITS  = 16;
	localparam int POS_BITS   = DELAY_BITS + FRAC_BITS;
	localparam int RESET_DELAY = 36000;

	localparam int SMOOTH_COEF      = 300648;
	localparam int SMOOTH_COEF_BITS = 20;
	localparam int SMOOTH_SHIFT     = 32;

	localparam int FB_BITS  = 17;
	localparam int FB_FRAC  = 16;
	localparam int FB_ONE   = 65536;
	localparam int LVL_BITS = 16;
	localparam int LVL_FRAC = 14;
	localparam int LVL_MAX  = 32768;

	localparam int CFG_IDX_BITS  = 8;
	localparam int CFG_DATA_BITS = 17;

	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_DELAY  = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_FEEDBACK_GAIN = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_DRY_GAIN      = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_SEND_GAIN     = CFG_IDX_BITS'(3);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SMOOTH,
		ST_UPDATE,
		ST_READ_A,
		ST_READ_B,
		ST_INTERP,
		ST_FEEDBACK,
		ST_WRITE,
		ST_DONE
	} sfd_state_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic smooth;
		logic update;
		logic read_a;
		logic read_b;
		logic interp;
		logic feedback;
		logic write;
		logic load_out;
	} sfd_cmd_t;

	typedef struct packed {
		logic clear_done;
	} sfd_sts_t;

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SAT_BITS-1:0] v
	);
		logic signed [SAT_BITS-1:0] hi;
		logic signed [SAT_BITS-1:0] lo;
		hi = {{(SAT_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
		lo = ~hi;
		if (v > hi) begin
			return hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			return lo[SAMPLE_BITS-1:0];
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### src/sfd_if.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay channels
// Sample input, result output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfd_in_if import sfd_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, left_in, right_in, input ready);
	modport sink (input valid, left_in, right_in, output ready);
endinterface

interface sfd_out_if import sfd_pkg::*;;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;

	modport source (output valid, left_out, right_out, input ready);
	modport sink (input valid, left_out, right_out, output ready);
endinterface

interface sfd_cfg_if import sfd_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/sfd_ring.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay ring memory
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ring #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

### src/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay controller
// Sequences ring clearing, smoothing, tap reads, ring write and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_ctrl import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	input  sfd_sts_t   sts,
	output sfd_cmd_t   cmd,
	output sfd_state_t state
);

	sfd_state_t state_q;
	sfd_state_t state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign state     = state_q;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_SMOOTH;
				end
			end
			ST_SMOOTH:   state_nxt = ST_UPDATE;
			ST_UPDATE:   state_nxt = ST_READ_A;
			ST_READ_A:   state_nxt = ST_READ_B;
			ST_READ_B:   state_nxt = ST_INTERP;
			ST_INTERP:   state_nxt = ST_FEEDBACK;
			ST_FEEDBACK: state_nxt = ST_WRITE;
			ST_WRITE:    state_nxt = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:     state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR:    cmd.clear    = 1'b1;
			ST_IDLE:     cmd.capture  = in_valid;
			ST_SMOOTH:   cmd.smooth   = 1'b1;
			ST_UPDATE:   cmd.update   = 1'b1;
			ST_READ_A:   cmd.read_a   = 1'b1;
			ST_READ_B:   cmd.read_b   = 1'b1;
			ST_INTERP:   cmd.interp   = 1'b1;
			ST_FEEDBACK: cmd.feedback = 1'b1;
			ST_WRITE:    cmd.write    = 1'b1;
			ST_DONE:     cmd.load_out = out_free;
			default:     cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### src/sfd_datapath.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay datapath
// Register file, delay smoother, ring addressing and per-channel arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_datapath import sfd_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	sfd_cfg_if.sink                       cfg,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  sfd_cmd_t                      cmd,
	output sfd_sts_t                      sts,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out
);

	localparam int SW = SAMPLE_BITS;
	localparam int LP = SW + LVL_BITS + 1;
	localparam int GP = SW + FB_BITS + 1;
	localparam int IP = SW + 1 + FRAC_BITS + 1;
	localparam int IS = IP - FRAC_BITS;
	localparam int RP = IS + FB_BITS + 1;
	localparam int RS = RP - FB_FRAC;
	localparam int SP = POS_BITS + 1 + SMOOTH_COEF_BITS;
	localparam int SS = SP - SMOOTH_SHIFT;

	localparam logic signed [SMOOTH_COEF_BITS-1:0] COEF = SMOOTH_COEF_BITS'(SMOOTH_COEF);

	logic [DELAY_BITS-1:0] target_q;
	logic [FB_BITS-1:0]    fb_gain_q;
	logic [LVL_BITS-1:0]   dry_gain_q;
	logic [LVL_BITS-1:0]   send_gain_q;
	logic [FB_BITS-1:0]    fb_lim;
	logic [FB_BITS-1:0]    fb_rest;
	logic [LVL_BITS-1:0]   dry_lim;
	logic [LVL_BITS-1:0]   snd_lim;

	logic [POS_BITS-1:0]        pos_q;
	logic signed [POS_BITS:0]   pos_diff;
	logic signed [SP-1:0]       smooth_prod_q;
	logic signed [SS-1:0]       smooth_step;
	logic [DELAY_BITS-1:0]      dly_int;
	logic [RING_AW-1:0]         dly;
	logic [RING_AW-1:0]         wp_q;
	logic [RING_AW-1:0]         clr_q;
	logic [RING_AW-1:0]         addr_a;
	logic [RING_AW-1:0]         addr_a_q;
	logic [RING_AW-1:0]         ring_addr;
	logic                       ring_en;
	logic                       ring_we;

	logic signed [SW-1:0] x_q           [2];
	logic signed [LP-1:0] send_prod_q   [2];
	logic signed [LP-1:0] dry_prod_q    [2];
	logic signed [SW-1:0] send_q        [2];
	logic signed [GP-1:0] wsend_prod_q  [2];
	logic signed [SW-1:0] a_q           [2];
	logic signed [SW:0]   diff_ab       [2];
	logic signed [IP-1:0] interp_prod_q [2];
	logic signed [IS-1:0] rd            [2];
	logic signed [RP-1:0] fbr_prod_q    [2];
	logic signed [RS-1:0] fbr           [2];
	logic signed [SW-1:0] ring_val      [2];
	logic signed [SW-1:0] res           [2];
	logic signed [SW-1:0] res_q         [2];
	logic signed [SW-1:0] out_q         [2];
	logic [SW-1:0]        rdata         [2];
	logic [SW-1:0]        wdata         [2];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= DELAY_BITS'(RESET_DELAY);
			fb_gain_q   <= '0;
			dry_gain_q  <= '0;
			send_gain_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TARGET_DELAY:  target_q    <= cfg.data[DELAY_BITS-1:0];
				REG_FEEDBACK_GAIN: fb_gain_q   <= cfg.data[FB_BITS-1:0];
				REG_DRY_GAIN:      dry_gain_q  <= cfg.data[LVL_BITS-1:0];
				REG_SEND_GAIN:     send_gain_q <= cfg.data[LVL_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign fb_lim  = (fb_gain_q > FB_BITS'(FB_ONE)) ? FB_BITS'(FB_ONE) : fb_gain_q;
	assign fb_rest = FB_BITS'(FB_ONE) - fb_lim;
	assign dry_lim = (dry_gain_q > LVL_BITS'(LVL_MAX)) ? LVL_BITS'(LVL_MAX) : dry_gain_q;
	assign snd_lim = (send_gain_q > LVL_BITS'(LVL_MAX)) ? LVL_BITS'(LVL_MAX) : send_gain_q;

	assign pos_diff    = signed'({1'b0, target_q, FRAC_BITS'(0)}) - signed'({1'b0, pos_q});
	assign smooth_step = signed'(smooth_prod_q[SP-1:SMOOTH_SHIFT]);
	assign dly_int     = pos_q[POS_BITS-1:FRAC_BITS];
	assign dly         = (32'(dly_int) > 32'(RING_DEPTH - 1)) ? RING_AW'(RING_DEPTH - 1)
		: RING_AW'(dly_int);
	assign addr_a      = wp_q - dly;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= {DELAY_BITS'(RESET_DELAY), FRAC_BITS'(0)};
			wp_q  <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.update) begin
				pos_q <= pos_q + POS_BITS'(smooth_step);
			end
			if (cmd.write) begin
				wp_q <= wp_q + RING_AW'(1);
			end
			if (cmd.clear) begin
				clr_q <= clr_q + RING_AW'(1);
			end
		end
	end

	assign sts.clear_done = &clr_q;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			diff_ab[i]  = (SW+1)'(signed'(rdata[i])) - (SW+1)'(a_q[i]);
			rd[i]       = IS'(a_q[i]) + signed'(interp_prod_q[i][IP-1:FRAC_BITS]);
			fbr[i]      = signed'(fbr_prod_q[i][RP-1:FB_FRAC]);
			ring_val[i] = sat_sample(SAT_BITS'(fbr[i]) + SAT_BITS'(send_q[i]));
			res[i]      = sat_sample(SAT_BITS'(signed'(dry_prod_q[i][LP-1:LVL_FRAC]))
				+ SAT_BITS'(fbr[i]) + SAT_BITS'(signed'(wsend_prod_q[i][GP-1:FB_FRAC])));
			wdata[i]    = cmd.clear ? '0 : ring_val[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.smooth) begin
			smooth_prod_q <= pos_diff * COEF;
		end
		if (cmd.read_a) begin
			addr_a_q <= addr_a;
		end
		for (int i = 0; i < 2; i++) begin
			if (cmd.smooth) begin
				send_prod_q[i] <= x_q[i] * signed'({1'b0, snd_lim});
				dry_prod_q[i]  <= x_q[i] * signed'({1'b0, dry_lim});
			end
			if (cmd.update) begin
				send_q[i] <= sat_sample(SAT_BITS'(signed'(send_prod_q[i][LP-1:LVL_FRAC])));
			end
			if (cmd.read_a) begin
				wsend_prod_q[i] <= send_q[i] * signed'({1'b0, fb_rest});
			end
			if (cmd.read_b) begin
				a_q[i] <= signed'(rdata[i]);
			end
			if (cmd.interp) begin
				interp_prod_q[i] <= diff_ab[i] * signed'({1'b0, pos_q[FRAC_BITS-1:0]});
			end
			if (cmd.feedback) begin
				fbr_prod_q[i] <= rd[i] * signed'({1'b0, fb_lim});
			end
			if (cmd.write) begin
				res_q[i] <= res[i];
			end
			if (cmd.load_out) begin
				out_q[i] <= res_q[i];
			end
		end
		if (cmd.capture) begin
			x_q[0] <= left_in;
			x_q[1] <= right_in;
		end
	end

	always_comb begin
		case (1'b1)
			cmd.clear:  ring_addr = clr_q;
			cmd.read_a: ring_addr = addr_a;
			cmd.read_b: ring_addr = addr_a_q - RING_AW'(1);
			default:    ring_addr = wp_q;
		endcase
	end

	assign ring_en = cmd.clear | cmd.read_a | cmd.read_b | cmd.write;
	assign ring_we = cmd.clear | cmd.write;

	for (genvar g = 0; g < 2; g++) begin : g_lane
		sfd_ring #(
			.DEPTH(RING_DEPTH),
			.WIDTH(SAMPLE_BITS)
		) u_ring (
			.clk  (clk),
			.en   (ring_en),
			.we   (ring_we),
			.addr (ring_addr),
			.wdata(wdata[g]),
			.rdata(rdata[g])
		);
	end

	assign left_out  = out_q[0];
	assign right_out = out_q[1];

endmodule

`default_nettype wire

### src/stereo_feedback_delay.sv
// ----------------------------------------------------------------------------
// Stereo feedback delay
// Two feedback delay rings with a smoothed, interpolated delay time.
// ----------------------------------------------------------------------------
// After reset the block sweeps all 131072 entries of both rings to zero, one
// entry per cycle; no sample word is accepted during the sweep, while
// register writes are taken at any time. Then each stereo word passes
// through these steps before the next word is accepted: one registered
// multiply for the delay smoother, the update of the delay position, two
// tap reads and one write on each ring's single port, and registered
// multiplies for the interpolation and the feedback. A finished result
// waits in the output register and the next word is accepted meanwhile;
// the hand-off stalls only if the previous result has still not been taken.
`default_nettype none

`include "stereo_feedback_delay_macros.svh"

module stereo_feedback_delay import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfd_in_if.sink    samples,
	sfd_out_if.source results,
	sfd_cfg_if.sink   cfg
);

	sfd_cmd_t   cmd;
	sfd_sts_t   sts;
	sfd_state_t state;

	sfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.sts      (sts),
		.cmd      (cmd),
		.state    (state)
	);

	sfd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.left_in  (samples.left_in),
		.right_in (samples.right_in),
		.cmd      (cmd),
		.sts      (sts),
		.left_out (results.left_out),
		.right_out(results.right_out)
	);

	`SFD_ASSERT_NEXT(a_one_word, samples.valid && samples.ready, !samples.ready, "word accepted while busy")
	`SFD_ASSERT_NOW(a_load_free, cmd.load_out, !results.valid || results.ready, "result overwritten")
	`SFD_ASSERT_NEXT(a_load_valid, cmd.load_out, results.valid, "loaded result not presented")
	`SFD_ASSERT_NOW(a_no_accept_clear, state == ST_CLEAR, !samples.ready, "word accepted during clear")

endmodule

`default_nettype wire

### bench/sfd_mix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo feedback delay checker
// Watches the register, sample and result channels, keeps its own copy of
// the delay rings, glide position and levels, works out the mixed pair for
// every accepted sample word and compares it with the next result word.
// ----------------------------------------------------------------------------
module sfd_mix_checker import sfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sfd_in_if    samples,
	sfd_out_if   results,
	sfd_cfg_if   cfg,
	output int   fail_count,
	output int   pending,
	output int   checked
);

	localparam int MAX_REPORTS = 40;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] l_mix;
		logic signed [SAMPLE_BITS-1:0] r_mix;
	} mix_pair_t;

	logic [DELAY_BITS-1:0] delay_reg;
	logic [FB_BITS-1:0]    fb_reg;
	logic [LVL_BITS-1:0]   dry_reg;
	logic [LVL_BITS-1:0]   send_reg;

	logic [POS_BITS-1:0] glide_pos;
	int                  head_pos;
	int                  tap_ring [2][RING_DEPTH];
	mix_pair_t           due_mix [$];
	int                  reports;
	int                  ci;
	int                  ri;
	mix_pair_t           fresh;
	mix_pair_t           oldest;

	function automatic longint clip_sample(input longint v);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	task automatic mix_sample_pair(input longint x_l, input longint x_r, output mix_pair_t res);
		longint target_q, pos, frac, fb, dry, snd;
		longint a, b, rd, send, fbr, wet;
		longint x [2];
		longint y [2];
		int whole, ia, ib, ch;
		x[0] = x_l;
		x[1] = x_r;
		target_q = longint'(delay_reg) <<< FRAC_BITS;
		pos = longint'(glide_pos);
		pos = pos + (((target_q - pos) * SMOOTH_COEF) >>> SMOOTH_SHIFT);
		glide_pos = POS_BITS'(pos);
		whole = int'(glide_pos >> FRAC_BITS);
		if (whole > RING_DEPTH - 1) begin
			whole = RING_DEPTH - 1;
		end
		frac = longint'(glide_pos[FRAC_BITS-1:0]);
		fb = (fb_reg > FB_ONE) ? longint'(FB_ONE) : longint'(fb_reg);
		dry = (dry_reg > LVL_MAX) ? longint'(LVL_MAX) : longint'(dry_reg);
		snd = (send_reg > LVL_MAX) ? longint'(LVL_MAX) : longint'(send_reg);
		for (ch = 0; ch < 2; ch++) begin
			ia = (head_pos + RING_DEPTH - whole) % RING_DEPTH;
			ib = (ia + RING_DEPTH - 1) % RING_DEPTH;
			a = longint'(tap_ring[ch][ia]);
			b = longint'(tap_ring[ch][ib]);
			rd = a + (((b - a) * frac) >>> FRAC_BITS);
			send = clip_sample((x[ch] * snd) >>> LVL_FRAC);
			fbr = (fb * rd) >>> FB_FRAC;
			tap_ring[ch][head_pos] = int'(clip_sample(fbr + send));
			wet = fbr + (((FB_ONE - fb) * send) >>> FB_FRAC);
			y[ch] = clip_sample(((x[ch] * dry) >>> LVL_FRAC) + wet);
		end
		head_pos = (head_pos + 1) % RING_DEPTH;
		res.l_mix = SAMPLE_BITS'(y[0]);
		res.r_mix = SAMPLE_BITS'(y[1]);
	endtask

	task automatic report_field(input string field, input longint want, input longint got);
		fail_count++;
		if (reports < MAX_REPORTS) begin
			$display("%0t mismatch on %s: expected %0d actual %0d", $time, field, want, got);
		end
		reports++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_reg = DELAY_BITS'(RESET_DELAY);
			fb_reg = '0;
			dry_reg = '0;
			send_reg = '0;
			glide_pos = POS_BITS'(RESET_DELAY) << FRAC_BITS;
			head_pos = 0;
			for (ci = 0; ci < 2; ci++) begin
				for (ri = 0; ri < RING_DEPTH; ri++) begin
					tap_ring[ci][ri] = 0;
				end
			end
			due_mix.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			reports = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_TARGET_DELAY: delay_reg = cfg.data[DELAY_BITS-1:0];
					REG_FEEDBACK_GAIN: fb_reg = cfg.data[FB_BITS-1:0];
					REG_DRY_GAIN: dry_reg = cfg.data[LVL_BITS-1:0];
					REG_SEND_GAIN: send_reg = cfg.data[LVL_BITS-1:0];
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				if (due_mix.size() == 0) begin
					fail_count++;
					$display("%0t result word with nothing due: actual %0d %0d", $time,
						results.left_out, results.right_out);
				end else begin
					oldest = due_mix.pop_front();
					if (results.left_out !== oldest.l_mix) begin
						report_field("left_out", oldest.l_mix, results.left_out);
					end
					if (results.right_out !== oldest.r_mix) begin
						report_field("right_out", oldest.r_mix, results.right_out);
					end
					checked++;
				end
			end
			if (samples.valid && samples.ready) begin
				mix_sample_pair(longint'(samples.left_in), longint'(samples.right_in), fresh);
				due_mix.push_back(fresh);
			end
			pending = due_mix.size();
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo feedback delay testbench
// Drives sample words and register writes into the delay, with phases of
// random idling on both sides and one long result hold-off, and leaves the
// prediction and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
	import sfd_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int QUIET_LIMIT  = 600000;
	localparam int HOLD_CYCLES  = 300;
	localparam int GLIDE_WORDS  = 100;
	localparam int PHASE_WORDS  = 160;
	localparam int RANDOM_PHASES = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_SPARE = REG_SEND_GAIN + 1'b1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LAST_SPARE  = '1;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_ALT = {(SAMPLE_BITS/2){2'b01}};

	localparam logic signed [SAMPLE_BITS-1:0] EDGE_L [8] =
		'{S_MAX, S_MIN, '0, '1, S_MAX, S_MIN, S_ALT, ~S_ALT};
	localparam logic signed [SAMPLE_BITS-1:0] EDGE_R [8] =
		'{S_MIN, S_MAX, '0, SAMPLE_BITS'(1), S_MAX, S_MIN, ~S_ALT, S_ALT};

	logic clk;
	logic arst_n;
	logic hold_req;
	int   src_pct;
	int   sink_pct;
	int   fail_count;
	int   pending;
	int   checked;
	int   words_sent;
	int   settings_used;
	int   quiet;

	sfd_in_if  samples_if ();
	sfd_out_if results_if ();
	sfd_cfg_if cfg_if ();

	stereo_feedback_delay u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	sfd_mix_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples_if),
		.results    (results_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	function automatic bit sender_gap();
		return $urandom_range(99) < src_pct;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3, 4: return SAMPLE_BITS'(int'($urandom_range(8191)) - 4096);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_level(input int unsigned top_val,
		input int unsigned field_max);
		case ($urandom_range(5))
			0: return 0;
			1: return top_val;
			2: return field_max;
			default: return $urandom_range(top_val);
		endcase
	endfunction

	task automatic push_pair(input logic signed [SAMPLE_BITS-1:0] l,
		input logic signed [SAMPLE_BITS-1:0] r);
		if (sender_gap()) begin
			samples_if.valid <= 1'b0;
			do @(negedge clk); while (sender_gap());
		end
		samples_if.valid <= 1'b1;
		samples_if.left_in <= l;
		samples_if.right_in <= r;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= CFG_DATA_BITS'(value);
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_results();
		samples_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (12) @(negedge clk);
	endtask

	task automatic apply_setting(input int unsigned tgt, input int unsigned fb,
		input int unsigned dry, input int unsigned snd);
		drain_results();
		write_reg(REG_TARGET_DELAY, tgt);
		write_reg(REG_FEEDBACK_GAIN, fb);
		write_reg(REG_DRY_GAIN, dry);
		write_reg(REG_SEND_GAIN, snd);
		settings_used++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			results_if.ready <= ($urandom_range(99) >= sink_pct);
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t watchdog: no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int i;
		int ph;
		arst_n = 1'b0;
		hold_req = 1'b0;
		src_pct = 0;
		sink_pct = 0;
		words_sent = 0;
		settings_used = 0;
		samples_if.valid = 1'b0;
		samples_if.left_in = '0;
		samples_if.right_in = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: field extremes under extreme and above-range levels
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					apply_setting(4800, 131071, 65535, 65535);
					write_reg(REG_FIRST_SPARE, 131071);
					write_reg(REG_LAST_SPARE, 0);
				end
				1: apply_setting(120000, FB_ONE, LVL_MAX, 0);
				default: apply_setting(131071, 0, 0, LVL_MAX);
			endcase
			for (i = 0; i < 8; i++) begin
				push_pair(EDGE_L[i], EDGE_R[i]);
			end
		end

		// glide the delay down toward zero
		apply_setting(0, 45000, 16384, 16384);
		for (i = 0; i < GLIDE_WORDS; i++) begin
			push_pair(pick_sample(), pick_sample());
		end

		// hold results off while words keep coming
		apply_setting(60000, FB_ONE, 8192, 20000);
		hold_req <= 1'b1;
		for (i = 0; i < 24; i++) begin
			push_pair(pick_sample(), pick_sample());
		end

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(4))
				0: apply_setting(4800, pick_level(FB_ONE, 131071),
					pick_level(LVL_MAX, 65535), pick_level(LVL_MAX, 65535));
				1: apply_setting(120000, pick_level(FB_ONE, 131071),
					pick_level(LVL_MAX, 65535), pick_level(LVL_MAX, 65535));
				2: apply_setting(0, pick_level(FB_ONE, 131071),
					pick_level(LVL_MAX, 65535), pick_level(LVL_MAX, 65535));
				3: apply_setting(131071, pick_level(FB_ONE, 131071),
					pick_level(LVL_MAX, 65535), pick_level(LVL_MAX, 65535));
				default: apply_setting($urandom_range(131071), pick_level(FB_ONE, 131071),
					pick_level(LVL_MAX, 65535), pick_level(LVL_MAX, 65535));
			endcase
			case (ph % 4)
				0: begin
					src_pct <= 0;
					sink_pct <= 0;
				end
				1: begin
					src_pct <= 81;
					sink_pct <= 0;
				end
				2: begin
					src_pct <= 0;
					sink_pct <= 81;
				end
				default: begin
					src_pct <= 10;
					sink_pct <= 10;
				end
			endcase
			for (i = 0; i < PHASE_WORDS; i++) begin
				push_pair(pick_sample(), pick_sample());
			end
		end

		drain_results();
		$display("Sent %0d sample words under %0d register settings, %0d results checked,",
			words_sent, settings_used, checked);
		$display("including a delay glide toward zero and a full-stall hold-off.");
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+src
src/sfd_pkg.sv
src/sfd_if.sv
src/sfd_ring.sv
src/sfd_ctrl.sv
src/sfd_datapath.sv
src/stereo_feedback_delay.sv
bench/sfd_mix_checker.sv
bench/testbench.sv
